[rtl/core/quad_mesh_opposite_edge_walk_core_assert.svh]
// Assertion macros for the quad mesh opposite edge walk core
`ifndef QUAD_MESH_OPPOSITE_EDGE_WALK_CORE_ASSERT_SVH
`define QUAD_MESH_OPPOSITE_EDGE_WALK_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define QMOE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qmoe assertion failed");

// next-cycle implication, disabled in reset
`define QMOE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qmoe assertion failed");

`endif

[rtl/core/qmoe_pkg.sv]
// Shared types and codes for the quad mesh opposite edge walk core
package qmoe_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_WALK   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_LOADED  = 3'd0;
   localparam logic [2:0] STATUS_FULL    = 3'd1;
   localparam logic [2:0] STATUS_FOUND   = 3'd2;
   localparam logic [2:0] STATUS_FAILED  = 3'd3;
   localparam logic [2:0] STATUS_CLEARED = 3'd4;

   localparam int CORNERS = 4;

   typedef struct packed {
      logic       hit;
      logic [1:0] pos;
   } match_type;

endpackage

[rtl/core/qmoe_face_ram.sv]
// Face table memory: one write port, one registered read port
module qmoe_face_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/qmoe_edge_match.sv]
// Edge compare unit: tests one face for a directed edge, gives the following edge
module qmoe_edge_match #(
   parameter int VERTEX_BITS = 16
) (
   input  logic [4*VERTEX_BITS-1:0] face,
   input  logic [VERTEX_BITS-1:0]   key_u,
   input  logic [VERTEX_BITS-1:0]   key_v,
   output qmoe_pkg::match_type      match,
   output logic [VERTEX_BITS-1:0]   opp_from,
   output logic [VERTEX_BITS-1:0]   opp_to
);

   logic [VERTEX_BITS-1:0] corner [qmoe_pkg::CORNERS];
   logic                   u_found;
   logic                   v_found;
   logic [1:0]             u_pos;
   logic [1:0]             v_pos;

   always_comb begin
      for (int i = 0; i < qmoe_pkg::CORNERS; i++) begin
         corner[i] = face[i*VERTEX_BITS +: VERTEX_BITS];
      end
   end

   // first position of each key; highest index scanned first so the lowest wins
   always_comb begin
      u_found = 1'b0;
      v_found = 1'b0;
      u_pos   = 2'd0;
      v_pos   = 2'd0;
      for (int i = qmoe_pkg::CORNERS - 1; i >= 0; i--) begin
         if (corner[i] == key_u) begin
            u_found = 1'b1;
            u_pos   = 2'(i);
         end
         if (corner[i] == key_v) begin
            v_found = 1'b1;
            v_pos   = 2'(i);
         end
      end
   end

   assign match.hit = u_found && v_found && ((u_pos + 2'd1) == v_pos);
   assign match.pos = u_pos;
   assign opp_from  = corner[u_pos + 2'd1];
   assign opp_to    = corner[u_pos + 2'd2];

endmodule

[rtl/core/quad_mesh_opposite_edge_walk_core.sv]
// Top level of the quad mesh opposite edge walk core: sequencer, face count and output register
//
// Usage:
//   req_ channel takes one transaction per command: tuser carries the operation
//   (load quad, walk from edge, clear table), tdata the four corners and the query edge.
//   rsp_ channel returns one transaction per load, walk or clear: tuser the status,
//   tdata the opposite edge and the neighbouring face (zero unless the walk is found).
//   The unused operation code is taken and gives no response.
// Timing:
//   Load and clear: the request moves the sequencer to the emit state, which fills the
//   output register once it is free. Walk: two passes over the stored faces through one
//   RAM read port and one edge compare unit, one face per cycle.
//   req_tready is high only while the sequencer is idle, so one command is in
//   work at a time; a command may be taken while the previous response waits.
// Reset: face count cleared, no response pending; face RAM contents are kept
//   but unreachable until rewritten.
// Stall: a response waits in the output register while rsp_tready is low; a
//   finished command holds the sequencer until the register is free.
module quad_mesh_opposite_edge_walk_core #(
   parameter int MAX_FACES   = 1024,
   parameter int VERTEX_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // operation
   input  logic [1:0]                               req_tuser,
   // corner_a, corner_b, corner_c, corner_d, edge_from, edge_to, zero pad
   input  logic [((6*VERTEX_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // status
   output logic [2:0]                               rsp_tuser,
   // opposite_from, opposite_to, next_face_a, next_face_b, next_face_c, next_face_d, zero pad
   output logic [((6*VERTEX_BITS+7)/8)*8-1:0]       rsp_tdata
);

   localparam int DATA_W = ((6*VERTEX_BITS+7)/8)*8;
   localparam int FACE_W = 4*VERTEX_BITS;
   localparam int RES_W  = 6*VERTEX_BITS;
   localparam int ADDR_W = $clog2(MAX_FACES);
   localparam int CNT_W  = $clog2(MAX_FACES+1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic                    phase_ff, phase_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic [CNT_W-1:0]        face_total_ff, face_total_in;
   logic [VERTEX_BITS-1:0]  key_u_ff, key_u_in;
   logic [VERTEX_BITS-1:0]  key_v_ff, key_v_in;
   logic [2:0]              res_status_ff, res_status_in;
   logic [RES_W-1:0]        res_data_ff, res_data_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [2:0]              rsp_tuser_ff, rsp_tuser_in;
   logic [DATA_W-1:0]       rsp_tdata_ff, rsp_tdata_in;

   logic                    req_txn;
   logic                    out_free;
   logic                    wr_en;
   logic                    rd_en;
   logic [FACE_W-1:0]       rd_face;
   qmoe_pkg::match_type     match;
   logic [VERTEX_BITS-1:0]  opp_from;
   logic [VERTEX_BITS-1:0]  opp_to;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_txn    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   qmoe_face_ram #(
      .DEPTH  (MAX_FACES),
      .WIDTH  (FACE_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (face_total_ff[ADDR_W-1:0]),
      .wr_data (req_tdata[FACE_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (rd_face)
   );

   qmoe_edge_match #(
      .VERTEX_BITS (VERTEX_BITS)
   ) u_match (
      .face     (rd_face),
      .key_u    (key_u_ff),
      .key_v    (key_v_ff),
      .match    (match),
      .opp_from (opp_from),
      .opp_to   (opp_to)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      rd_vld_in     = rd_vld_ff;
      scan_in       = scan_ff;
      face_total_in = face_total_ff;
      key_u_in      = key_u_ff;
      key_v_in      = key_v_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_txn) begin
               res_data_in = '0;
               case (req_tuser)
                  qmoe_pkg::OP_LOAD: begin
                     if (face_total_ff == CNT_W'(MAX_FACES)) begin
                        res_status_in = qmoe_pkg::STATUS_FULL;
                     end else begin
                        res_status_in = qmoe_pkg::STATUS_LOADED;
                        wr_en         = 1'b1;
                        face_total_in = face_total_ff + CNT_W'(1);
                     end
                     state_in = ST_EMIT;
                  end
                  qmoe_pkg::OP_CLEAR: begin
                     face_total_in = '0;
                     res_status_in = qmoe_pkg::STATUS_CLEARED;
                     state_in      = ST_EMIT;
                  end
                  qmoe_pkg::OP_WALK: begin
                     key_u_in  = req_tdata[4*VERTEX_BITS +: VERTEX_BITS];
                     key_v_in  = req_tdata[5*VERTEX_BITS +: VERTEX_BITS];
                     phase_in  = 1'b0;
                     scan_in   = '0;
                     rd_vld_in = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && match.hit) begin
               rd_vld_in = 1'b0;
               scan_in   = '0;
               if (!phase_ff) begin
                  // second pass looks for the following edge reversed
                  key_u_in = opp_to;
                  key_v_in = opp_from;
                  phase_in = 1'b1;
               end else begin
                  res_status_in = qmoe_pkg::STATUS_FOUND;
                  res_data_in   = {rd_face, opp_to, opp_from};
                  state_in      = ST_EMIT;
               end
            end else if (scan_ff != face_total_ff) begin
               rd_en     = 1'b1;
               scan_in   = scan_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end else if (rd_vld_ff) begin
               rd_vld_in = 1'b0;
            end else begin
               res_status_in = qmoe_pkg::STATUS_FAILED;
               res_data_in   = '0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = DATA_W'(res_data_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_u_ff      <= key_u_in;
      key_v_ff      <= key_v_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      phase_ff      <= phase_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         face_total_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         face_total_ff <= face_total_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[rtl/core/qmoe_checker.sv]
// Port-level checker for the quad mesh opposite edge walk core, with its bind
`include "quad_mesh_opposite_edge_walk_core_assert.svh"

module qmoe_checker #(
   parameter int DATA_W = 96
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [1:0]        req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [2:0]        rsp_tuser,
   input logic [DATA_W-1:0] rsp_tdata
);

   // a stalled response keeps its payload
   `QMOE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one command in work at a time
   `QMOE_ASSERT_NEXT(a_busy_after_txn, clock, reset, req_tvalid && req_tready && (req_tuser != qmoe_pkg::OP_UNUSED), !req_tready)

   // only a found walk carries edge and face data
   `QMOE_ASSERT_NOW(a_zero_unless_found, clock, reset, rsp_tvalid && (rsp_tuser != qmoe_pkg::STATUS_FOUND), rsp_tdata == '0)

endmodule

bind quad_mesh_opposite_edge_walk_core qmoe_checker #(
   .DATA_W (DATA_W)
) u_qmoe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
